@@ design/dft_pkg.sv @@
// Package for the DALI forward-frame transmitter.
// Holds the phase type, item codes, the result struct and shared constants.
// No dependencies.
package dft_pkg;

  // Width of the frame field on the input channel
  localparam int unsigned IN_FRAME_W = 16;

  // Default number of bits in one forward frame
  localparam int unsigned FRAME_BITS_DEF = 16;

  // Item mode codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  // One result item
  typedef struct packed {
    logic line_level;
    logic frame_done;
    logic busy_res;
  } tx_result_t;

endpackage

@@ design/dft_chan_if.sv @@
// Valid/ready channel interfaces for the DALI forward-frame transmitter.
// Depends on dft_pkg for the frame width.
interface dft_in_if
  import dft_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [IN_FRAME_W-1:0] frame;

  modport source (output valid, output mode, output frame, input ready);
  modport sink   (input valid, input mode, input frame, output ready);
endinterface

interface dft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic frame_done;
  logic busy_res;

  modport source (output valid, output line_level, output frame_done, output busy_res,
                  input ready);
  modport sink   (input valid, input line_level, input frame_done, input busy_res,
                  output ready);
endinterface

@@ design/dft_tx_core.sv @@
// Manchester sequencer core: frame, phase and bit-position registers.
// Advances one half-bit per accepted tick item. Depends on dft_pkg.
module dft_tx_core
  import dft_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,   // item accepted this cycle
  input  logic                  mode,
  input  logic [IN_FRAME_W-1:0] frame,
  output tx_result_t            result_nxt // result after this item
);

  localparam int unsigned POS_W = $clog2(FRAME_BITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

  phase_t                phase_r, phase_nxt;
  logic                  second_half_r, second_half_nxt;
  logic [POS_W-1:0]      bit_pos_r, bit_pos_nxt;
  logic [FRAME_BITS-1:0] held_frame_r, held_frame_nxt;
  logic                  pin_level_r, pin_level_nxt;
  logic                  done_flag_r, done_flag_nxt;
  logic                  cur_bit;

  assign cur_bit = held_frame_r[bit_pos_r];

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    second_half_nxt = second_half_r;
    bit_pos_nxt     = bit_pos_r;
    held_frame_nxt  = held_frame_r;
    pin_level_nxt   = pin_level_r;
    done_flag_nxt   = done_flag_r;
    if (mode == MODE_LOAD) begin
      // load is dropped unless idle
      if (phase_r == PH_IDLE) begin
        held_frame_nxt  = FRAME_BITS'(frame);
        phase_nxt       = PH_START;
        second_half_nxt = 1'b0;
        bit_pos_nxt     = POS_LAST;
      end
    end else begin
      case (phase_r)
        PH_START: begin
          if (!second_half_r) begin
            done_flag_nxt   = 1'b0;
            pin_level_nxt   = 1'b1;
            second_half_nxt = 1'b1;
          end else begin
            pin_level_nxt   = 1'b0;
            second_half_nxt = 1'b0;
            phase_nxt       = PH_DATA;
          end
        end
        PH_DATA: begin
          if (!second_half_r) begin
            pin_level_nxt   = cur_bit;
            second_half_nxt = 1'b1;
          end else begin
            pin_level_nxt   = ~cur_bit;
            second_half_nxt = 1'b0;
            if (bit_pos_r == '0) begin
              bit_pos_nxt = POS_LAST;
              phase_nxt   = PH_STOP;
            end else begin
              bit_pos_nxt = bit_pos_r - 1'b1;
            end
          end
        end
        PH_STOP: begin
          pin_level_nxt   = 1'b0;
          done_flag_nxt   = 1'b1;
          phase_nxt       = PH_IDLE;
          second_half_nxt = 1'b0;
        end
        default: begin
          // idle tick: hold everything
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    result_nxt.line_level = pin_level_nxt;
    result_nxt.frame_done = done_flag_nxt;
    result_nxt.busy_res   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      second_half_r <= 1'b0;
      bit_pos_r     <= POS_LAST;
      pin_level_r   <= 1'b0;
      done_flag_r   <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      second_half_r <= second_half_nxt;
      bit_pos_r     <= bit_pos_nxt;
      pin_level_r   <= pin_level_nxt;
      done_flag_r   <= done_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      held_frame_r <= held_frame_nxt;
    end
  end

endmodule

@@ design/dali_forward_frame_transmitter.sv @@
// Top level of the DALI forward-frame transmitter.
// Depends on dft_pkg, dft_in_if / dft_out_if and dft_tx_core.

// DALI-style Manchester forward-frame transmitter. Every input item gives
// exactly one result item. A load item (mode = 1) latches a frame and arms
// the block; it is ignored while a frame is in flight. Each tick item
// (mode = 0) then moves the line by one half-bit: start bit high/low, data
// bits MSB first (one = high/low, zero = low/high), and one low stop half-bit
// that sets frame_done and returns to idle. frame_done clears on the first
// half of the next start bit. Ticks while idle just repeat the current line
// level and flags. The result carries line level, done flag and busy after
// the item. Throughput is one item per clock unless the output stalls: the
// next state is computed combinationally from the sequencer registers, and
// the result is registered on acceptance; that output register doubles as the
// decoupling stage, so a new item is taken whenever the output is empty or
// being drained in the same cycle. FRAME_BITS sets the frame length (8..32);
// frame bits above the 16-bit input field are sent as zero.
module dali_forward_frame_transmitter
  import dft_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dft_in_if.sink      in_chan,
  dft_out_if.source   out_chan
);

  logic       in_accept;
  logic       out_valid_r;
  tx_result_t result_nxt;
  tx_result_t result_r;

  // Output stage drained or empty -> ready for the next item
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  dft_tx_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .mode       (in_chan.mode),
    .frame      (in_chan.frame),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.line_level = result_r.line_level;
  assign out_chan.frame_done = result_r.frame_done;
  assign out_chan.busy_res   = result_r.busy_res;

endmodule

@@ dv/tb_dali_forward_frame_transmitter.sv @@
// Self-checking testbench for the DALI forward-frame transmitter.
// Predicts each result from its own Manchester sequencer model and checks it.
// Depends on dft_pkg, dft_in_if / dft_out_if and the transmitter RTL.
module tb_dali_forward_frame_transmitter;
  import dft_pkg::*;

  localparam int unsigned FRAME_BITS     = FRAME_BITS_DEF;
  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned IDLE_PCT       = 26;
  // start bit (2) + data bits (2 each) + stop half-bit (1)
  localparam int unsigned TICKS_PER_FRAME = 2 + 2 * FRAME_BITS + 1;

  logic clk = 1'b0;
  logic rst_n;

  dft_in_if  in_if ();
  dft_out_if out_if ();

  dali_forward_frame_transmitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line model: mirror of the transmitter sequencer, advanced once per
  // accepted item. Results it produces wait in line_expect_q until the DUT
  // hands over the matching result item.
  // ---------------------------------------------------------------------------
  phase_t                tx_phase;
  logic                  tx_second_half;
  int unsigned           tx_bit_idx;
  logic [IN_FRAME_W-1:0] tx_frame;
  logic                  tx_pin;
  logic                  tx_done;

  tx_result_t line_expect_q[$];

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned frames_sent;
  int unsigned loads_ignored;
  int unsigned mismatches;

  // Idling controls for the sender and the receiver
  bit in_gaps_on;
  bit out_stalls_on;
  int unsigned hold_off_left;

  function automatic tx_result_t advance_line(input logic mode,
                                              input logic [IN_FRAME_W-1:0] frame);
    logic       data_bit;
    tx_result_t res;
    if (mode == MODE_LOAD) begin
      // A load only arms an idle block; it never touches the pin or done.
      if (tx_phase == PH_IDLE) begin
        tx_frame       = frame;
        tx_phase       = PH_START;
        tx_second_half = 1'b0;
        tx_bit_idx     = FRAME_BITS - 1;
      end else begin
        loads_ignored++;
      end
    end else begin
      case (tx_phase)
        PH_START: begin
          if (!tx_second_half) begin
            tx_done        = 1'b0;
            tx_pin         = 1'b1;
            tx_second_half = 1'b1;
          end else begin
            tx_pin         = 1'b0;
            tx_second_half = 1'b0;
            tx_phase       = PH_DATA;
          end
        end
        PH_DATA: begin
          // bits beyond the input field go out as zero
          data_bit = (tx_bit_idx < IN_FRAME_W) ? tx_frame[tx_bit_idx] : 1'b0;
          if (!tx_second_half) begin
            tx_pin         = data_bit;
            tx_second_half = 1'b1;
          end else begin
            tx_pin         = ~data_bit;
            tx_second_half = 1'b0;
            if (tx_bit_idx == 0) begin
              tx_bit_idx = FRAME_BITS - 1;
              tx_phase   = PH_STOP;
            end else begin
              tx_bit_idx--;
            end
          end
        end
        PH_STOP: begin
          tx_pin         = 1'b0;
          tx_done        = 1'b1;
          tx_phase       = PH_IDLE;
          tx_second_half = 1'b0;
          frames_sent++;
        end
        default: ;  // tick while idle: nothing moves
      endcase
    end
    res.line_level = tx_pin;
    res.frame_done = tx_done;
    res.busy_res   = (tx_phase != PH_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // item is taken. Valid stays high from one item to the next unless a gap
  // is inserted, so it only ever gets one assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic mode, input logic [IN_FRAME_W-1:0] frame);
    while (in_gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.frame <= frame;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    line_expect_q.push_back(advance_line(mode, frame));
    items_sent++;
    @(negedge clk);
  endtask

  // Park the sender until every predicted result has come back.
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    wait (line_expect_q.size() == 0);
    @(negedge clk);
  endtask

  // Load, full tick sequence, and a few idle ticks; busy loads are optional
  // noise that the block must drop.
  task automatic send_frame(input logic [IN_FRAME_W-1:0] frame, input int busy_load_pct,
                            output int unsigned n_items);
    int unsigned trailing;
    n_items = 0;
    send_item(MODE_LOAD, frame);
    n_items++;
    for (int unsigned i = 0; i < TICKS_PER_FRAME; i++) begin
      if ($urandom_range(0, 99) < busy_load_pct) send_item(MODE_LOAD, IN_FRAME_W'($urandom));
      send_item(MODE_TICK, IN_FRAME_W'($urandom));
      n_items++;
    end
    trailing = $urandom_range(0, 2);
    repeat (trailing) send_item(MODE_TICK, IN_FRAME_W'($urandom));
    n_items += trailing;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, or a hold-off counted down here in cycles.
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_if.ready <= 1'b0;
        hold_off_left--;
      end else if (out_stalls_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result taken is matched with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tx_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (line_expect_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: result with nothing expected: line=%0b done=%0b busy=%0b",
                   out_if.line_level, out_if.frame_done, out_if.busy_res);
        mismatches++;
      end else begin
        want = line_expect_q.pop_front();
        results_checked++;
        if (out_if.line_level !== want.line_level ||
            out_if.frame_done !== want.frame_done ||
            out_if.busy_res   !== want.busy_res) begin
          if (mismatches < MAX_REPORTS)
            $display("ERROR: result %0d (exp/got): line %0b/%0b done %0b/%0b busy %0b/%0b",
                     results_checked, want.line_level, out_if.line_level,
                     want.frame_done, out_if.frame_done, want.busy_res, out_if.busy_res);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks straight out of reset: the line stays low, no flags.
  task automatic test_idle_ticks();
    send_item(MODE_TICK, '0);
    send_item(MODE_TICK, '1);
    send_item(MODE_TICK, IN_FRAME_W'($urandom));
  endtask

  // All-ones and all-zeros frames, with loads hitting every busy phase and a
  // load after done and an idle tick (done must survive the load until the start bit).
  task automatic test_frame_extremes();
    send_item(MODE_LOAD, '1);
    send_item(MODE_LOAD, 16'h5A5A);          // busy, before the start bit
    send_item(MODE_TICK, '0);
    send_item(MODE_LOAD, 16'h5A5A);          // busy, mid start bit
    for (int unsigned i = 1; i < TICKS_PER_FRAME; i++) begin
      if (i == 6 || i == TICKS_PER_FRAME - 1) send_item(MODE_LOAD, 16'h0F0F);  // data / stop
      send_item(MODE_TICK, IN_FRAME_W'($urandom));
    end
    send_item(MODE_TICK, '0);                // idle tick holds done
    send_item(MODE_LOAD, '0);
    repeat (TICKS_PER_FRAME) send_item(MODE_TICK, '1);
    send_item(MODE_LOAD, 16'h8001);          // MSB and LSB only
    repeat (TICKS_PER_FRAME) send_item(MODE_TICK, '0);
  endtask

  // Mostly complete frames with random content; the rest random noise items.
  task automatic run_random(input int unsigned target);
    int unsigned done_items;
    int unsigned n;
    logic [IN_FRAME_W-1:0] frame;
    done_items = 0;
    while (done_items < target) begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 9))
          0:       frame = '0;
          1:       frame = '1;
          default: frame = IN_FRAME_W'($urandom);
        endcase
        send_frame(frame, 4, n);
        done_items += n;
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) send_item(logic'($urandom_range(0, 1)), IN_FRAME_W'($urandom));
        done_items += n;
      end
    end
  endtask

  task automatic test_random_frames();
    run_random(450);
    // stretch with no idling on either side
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    run_random(300);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    run_random(500);
  endtask

  // Receiver holds off while the sender keeps going, so the block fills and
  // stalls its input; then the sender waits for the block to drain.
  task automatic test_backpressure();
    int unsigned n;
    wait_all_results();
    in_gaps_on    = 1'b0;
    hold_off_left = 150;
    send_frame(IN_FRAME_W'($urandom), 0, n);
    in_gaps_on = 1'b1;
    wait_all_results();
    send_frame(IN_FRAME_W'($urandom), 10, n);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_TICK;
    in_if.frame    = '0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    hold_off_left  = 0;
    items_sent     = 0;
    results_checked = 0;
    frames_sent    = 0;
    loads_ignored  = 0;
    mismatches     = 0;

    // line model reset state
    tx_phase       = PH_IDLE;
    tx_second_half = 1'b0;
    tx_bit_idx     = FRAME_BITS - 1;
    tx_frame       = '0;
    tx_pin         = 1'b0;
    tx_done        = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_ticks();
    test_frame_extremes();
    test_random_frames();
    test_backpressure();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d frames on the line, %0d loads dropped while busy.",
             items_sent, frames_sent, loads_ignored);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout with %0d results outstanding.", line_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
